FILE: src/ray_tri_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_tri_pkg
// Shared constants, payload structs and helpers for the ray/triangle
// intersection pipeline.
// ----------------------------------------------------------------------------
package ray_tri_pkg;

  localparam int COMP_W     = 21;
  localparam int FRAC_W     = 12;
  localparam int VEC_N      = 3;
  localparam int VEC_W      = VEC_N * COMP_W;
  localparam int DIST_W     = 32;
  localparam int DIST_FRAC  = 16;
  localparam int EPS_W      = 16;
  localparam int EPS_SHIFT  = 3 * FRAC_W - DIST_FRAC;

  localparam int TV_W       = COMP_W + 1;
  localparam int XP_W       = 2 * COMP_W + 1;
  localparam int XQ_W       = TV_W + COMP_W + 1;
  localparam int SUM_W      = TV_W + XQ_W + 2;
  localparam int DMAG_W     = 3 * COMP_W;
  localparam int SPLIT_W    = 32;
  localparam int QUO_W      = 32;
  localparam int REM_W      = DMAG_W + QUO_W;
  localparam int PROD_W     = COMP_W + QUO_W + 1;
  localparam int PT_W       = PROD_W - DIST_FRAC + 1;

  localparam int DIV_FIRST  = 8;
  localparam int PIPE_LAT   = DIV_FIRST + QUO_W + 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef logic        [VEC_W-1:0]          vec_t;
  typedef logic signed [COMP_W-1:0]         comp_t;
  typedef logic signed [TV_W-1:0]           tv_t;
  typedef logic signed [XP_W-1:0]           xp_t;
  typedef logic signed [XQ_W-1:0]           xq_t;
  typedef logic signed [SUM_W-1:0]          sum_t;
  typedef logic        [DMAG_W-1:0]         dmag_t;
  typedef logic signed [DIST_W+SPLIT_W:0]   part_t;
  typedef logic        [REM_W-1:0]          rem_t;
  typedef logic signed [REM_W:0]            wide_t;
  typedef logic signed [DIST_W-1:0]         dist_t;
  typedef logic        [QUO_W-1:0]          quo_t;
  typedef logic signed [QUO_W:0]            tq_t;
  typedef logic signed [PROD_W-1:0]         prod_t;
  typedef logic signed [PT_W-1:0]           pt_t;
  typedef logic        [EPS_W-1:0]          eps_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VERTEX_A    = 0,
    CFG_EDGE_AB     = 1,
    CFG_EDGE_AC     = 2,
    CFG_FACE_NORMAL = 3,
    CFG_EPSILON     = 4,
    CFG_CULL_MODE   = 5
  } cfg_reg_t;

  typedef struct packed {
    vec_t  ray_origin;
    vec_t  ray_direction;
    dist_t min_distance;
    dist_t max_distance;
  } in_item_t;

  typedef struct packed {
    logic  hit;
    dist_t hit_distance;
    vec_t  hit_point;
    vec_t  hit_normal;
  } out_item_t;

  function automatic comp_t get_comp(vec_t v, int k);
    return comp_t'(v[k*COMP_W +: COMP_W]);
  endfunction

endpackage

FILE: src/ray_triangle_intersect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Moller-Trumbore ray/triangle test, fully pipelined, exact fixed point.
// ----------------------------------------------------------------------------
// One ray is taken on every clock at which start is high (busy stays low), and
// its result appears on out_item with a one-cycle out_valid strobe, in order;
// there is no backpressure, so the receiver must take every strobe. The
// pipeline holds the 32 one-bit stages of the restoring divider that forms
// the hit distance, plus eight stages of cross/dot products and threshold,
// barycentric and window tests, and three stages for the hit point and output
// register. Configuration writes are taken every cycle (cfg_ready is high)
// and must only be issued while no ray is in flight.
// ----------------------------------------------------------------------------
module ray_triangle_intersect (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  ray_tri_pkg::in_item_t                  in_item,
  output logic                                   out_valid,
  output ray_tri_pkg::out_item_t                 out_item,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ray_tri_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ray_tri_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // configuration
  ray_tri_pkg::vec_t vertex_a_r, edge_ab_r, edge_ac_r, face_normal_r;
  ray_tri_pkg::eps_t epsilon_r;
  logic              cull_mode_r;

  // valid line
  logic [ray_tri_pkg::PIPE_LAT:1] v_r;

  // carried payload
  ray_tri_pkg::comp_t o_r    [1:ray_tri_pkg::PIPE_LAT-1][ray_tri_pkg::VEC_N];
  ray_tri_pkg::comp_t d_r    [1:ray_tri_pkg::PIPE_LAT-1][ray_tri_pkg::VEC_N];
  ray_tri_pkg::tv_t   tv_r   [1:3][ray_tri_pkg::VEC_N];
  ray_tri_pkg::dist_t tmin_r [1:ray_tri_pkg::DIV_FIRST-2];
  ray_tri_pkg::dist_t tmax_r [1:ray_tri_pkg::DIV_FIRST-2];

  // cross and dot products
  ray_tri_pkg::xq_t  pm_r [2*ray_tri_pkg::VEC_N];
  ray_tri_pkg::xq_t  qm_r [2*ray_tri_pkg::VEC_N];
  ray_tri_pkg::xp_t  pv_r [ray_tri_pkg::VEC_N];
  ray_tri_pkg::xq_t  qv_r [ray_tri_pkg::VEC_N];
  ray_tri_pkg::sum_t dp_det_r [ray_tri_pkg::VEC_N];
  ray_tri_pkg::sum_t dp_un_r  [ray_tri_pkg::VEC_N];
  ray_tri_pkg::sum_t dp_vn_r  [ray_tri_pkg::VEC_N];
  ray_tri_pkg::sum_t dp_tn_r  [ray_tri_pkg::VEC_N];
  ray_tri_pkg::sum_t det5_r, un5_r, vn5_r, tn5_r;

  // tests
  logic               rej6_r, rej7_r;
  ray_tri_pkg::dmag_t dmag6_r, dmag7_r;
  ray_tri_pkg::sum_t  un6_r, vn6_r, tn6_r, tn7_r;
  ray_tri_pkg::part_t plo_min_r, phi_min_r, plo_max_r, phi_max_r;

  // divider
  logic               dhit_r [0:ray_tri_pkg::QUO_W];
  logic               dneg_r [0:ray_tri_pkg::QUO_W];
  ray_tri_pkg::rem_t  drem_r [0:ray_tri_pkg::QUO_W];
  ray_tri_pkg::quo_t  dq_r   [0:ray_tri_pkg::QUO_W];
  ray_tri_pkg::dmag_t ddet_r [0:ray_tri_pkg::QUO_W];
  ray_tri_pkg::rem_t  ds     [1:ray_tri_pkg::QUO_W];
  logic               ge     [1:ray_tri_pkg::QUO_W];

  // hit point
  ray_tri_pkg::tq_t   tq41_r, tq42_r;
  logic               hit41_r, hit42_r;
  ray_tri_pkg::prod_t pr42_r [ray_tri_pkg::VEC_N];
  ray_tri_pkg::out_item_t out_item_r;

  // combinational
  ray_tri_pkg::comp_t vtx_a [ray_tri_pkg::VEC_N];
  ray_tri_pkg::comp_t e_ab  [ray_tri_pkg::VEC_N];
  ray_tri_pkg::comp_t e_ac  [ray_tri_pkg::VEC_N];
  ray_tri_pkg::comp_t in_o  [ray_tri_pkg::VEC_N];
  ray_tri_pkg::comp_t in_d  [ray_tri_pkg::VEC_N];
  ray_tri_pkg::tv_t   tv_nxt [ray_tri_pkg::VEC_N];
  ray_tri_pkg::xq_t   pm_nxt [2*ray_tri_pkg::VEC_N];
  ray_tri_pkg::xq_t   qm_nxt [2*ray_tri_pkg::VEC_N];
  ray_tri_pkg::xp_t   pv_nxt [ray_tri_pkg::VEC_N];
  ray_tri_pkg::xq_t   qv_nxt [ray_tri_pkg::VEC_N];
  ray_tri_pkg::sum_t  dp_det_nxt [ray_tri_pkg::VEC_N];
  ray_tri_pkg::sum_t  dp_un_nxt  [ray_tri_pkg::VEC_N];
  ray_tri_pkg::sum_t  dp_vn_nxt  [ray_tri_pkg::VEC_N];
  ray_tri_pkg::sum_t  dp_tn_nxt  [ray_tri_pkg::VEC_N];

  logic               det_neg, thr_fail, bary_fail, win_fail;
  ray_tri_pkg::sum_t  det_abs, eps_ext, dmag_ext;
  ray_tri_pkg::wide_t tn16, win_min, win_max;
  ray_tri_pkg::tq_t   tq_nxt;
  ray_tri_pkg::pt_t   pt [ray_tri_pkg::VEC_N];
  ray_tri_pkg::pt_t   lim_hi, lim_lo;
  ray_tri_pkg::vec_t  point_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign out_valid = v_r[ray_tri_pkg::PIPE_LAT];
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_a_r    <= '0;
      edge_ab_r     <= '0;
      edge_ac_r     <= '0;
      face_normal_r <= '0;
      epsilon_r     <= ray_tri_pkg::eps_t'(16);
      cull_mode_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ray_tri_pkg::CFG_VERTEX_A:    vertex_a_r    <= cfg_data[ray_tri_pkg::VEC_W-1:0];
        ray_tri_pkg::CFG_EDGE_AB:     edge_ab_r     <= cfg_data[ray_tri_pkg::VEC_W-1:0];
        ray_tri_pkg::CFG_EDGE_AC:     edge_ac_r     <= cfg_data[ray_tri_pkg::VEC_W-1:0];
        ray_tri_pkg::CFG_FACE_NORMAL: face_normal_r <= cfg_data[ray_tri_pkg::VEC_W-1:0];
        ray_tri_pkg::CFG_EPSILON:     epsilon_r     <= cfg_data[ray_tri_pkg::EPS_W-1:0];
        ray_tri_pkg::CFG_CULL_MODE:   cull_mode_r   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[ray_tri_pkg::PIPE_LAT-1:1], start && !busy};
    end
  end

  // stages 1..5: edge vectors, cross products, dot products
  always_comb begin
    for (int k = 0; k < ray_tri_pkg::VEC_N; k++) begin
      vtx_a[k]  = ray_tri_pkg::get_comp(vertex_a_r, k);
      e_ab[k]   = ray_tri_pkg::get_comp(edge_ab_r, k);
      e_ac[k]   = ray_tri_pkg::get_comp(edge_ac_r, k);
      in_o[k]   = ray_tri_pkg::get_comp(in_item.ray_origin, k);
      in_d[k]   = ray_tri_pkg::get_comp(in_item.ray_direction, k);
      tv_nxt[k] = ray_tri_pkg::tv_t'(in_o[k]) - ray_tri_pkg::tv_t'(vtx_a[k]);
    end
    pm_nxt[0] = ray_tri_pkg::xq_t'(d_r[1][1]) * ray_tri_pkg::xq_t'(e_ac[2]);
    pm_nxt[1] = ray_tri_pkg::xq_t'(d_r[1][2]) * ray_tri_pkg::xq_t'(e_ac[1]);
    pm_nxt[2] = ray_tri_pkg::xq_t'(d_r[1][2]) * ray_tri_pkg::xq_t'(e_ac[0]);
    pm_nxt[3] = ray_tri_pkg::xq_t'(d_r[1][0]) * ray_tri_pkg::xq_t'(e_ac[2]);
    pm_nxt[4] = ray_tri_pkg::xq_t'(d_r[1][0]) * ray_tri_pkg::xq_t'(e_ac[1]);
    pm_nxt[5] = ray_tri_pkg::xq_t'(d_r[1][1]) * ray_tri_pkg::xq_t'(e_ac[0]);
    qm_nxt[0] = ray_tri_pkg::xq_t'(tv_r[1][1]) * ray_tri_pkg::xq_t'(e_ab[2]);
    qm_nxt[1] = ray_tri_pkg::xq_t'(tv_r[1][2]) * ray_tri_pkg::xq_t'(e_ab[1]);
    qm_nxt[2] = ray_tri_pkg::xq_t'(tv_r[1][2]) * ray_tri_pkg::xq_t'(e_ab[0]);
    qm_nxt[3] = ray_tri_pkg::xq_t'(tv_r[1][0]) * ray_tri_pkg::xq_t'(e_ab[2]);
    qm_nxt[4] = ray_tri_pkg::xq_t'(tv_r[1][0]) * ray_tri_pkg::xq_t'(e_ab[1]);
    qm_nxt[5] = ray_tri_pkg::xq_t'(tv_r[1][1]) * ray_tri_pkg::xq_t'(e_ab[0]);
    for (int k = 0; k < ray_tri_pkg::VEC_N; k++) begin
      pv_nxt[k] = ray_tri_pkg::xp_t'(pm_r[2*k] - pm_r[2*k+1]);
      qv_nxt[k] = qm_r[2*k] - qm_r[2*k+1];
      dp_det_nxt[k] = ray_tri_pkg::sum_t'(e_ab[k]) * ray_tri_pkg::sum_t'(pv_r[k]);
      dp_un_nxt[k]  = ray_tri_pkg::sum_t'(tv_r[3][k]) * ray_tri_pkg::sum_t'(pv_r[k]);
      dp_vn_nxt[k]  = ray_tri_pkg::sum_t'(d_r[3][k]) * ray_tri_pkg::sum_t'(qv_r[k]);
      dp_tn_nxt[k]  = ray_tri_pkg::sum_t'(e_ac[k]) * ray_tri_pkg::sum_t'(qv_r[k]);
    end
  end

  // stages 6..8: threshold, barycentric and window tests
  always_comb begin
    det_neg  = det5_r[ray_tri_pkg::SUM_W-1];
    det_abs  = det_neg ? -det5_r : det5_r;
    eps_ext  = ray_tri_pkg::sum_t'({1'b0, epsilon_r}) <<< ray_tri_pkg::EPS_SHIFT;
    thr_fail = cull_mode_r ? (det5_r < eps_ext) : (det_abs < eps_ext);

    dmag_ext  = ray_tri_pkg::sum_t'({1'b0, dmag6_r});
    bary_fail = un6_r[ray_tri_pkg::SUM_W-1] || (un6_r > dmag_ext)
             || vn6_r[ray_tri_pkg::SUM_W-1] || ((un6_r + vn6_r) > dmag_ext);

    tn16     = ray_tri_pkg::wide_t'(tn7_r) <<< ray_tri_pkg::DIST_FRAC;
    win_min  = (ray_tri_pkg::wide_t'(phi_min_r) <<< ray_tri_pkg::SPLIT_W)
             + ray_tri_pkg::wide_t'(plo_min_r);
    win_max  = (ray_tri_pkg::wide_t'(phi_max_r) <<< ray_tri_pkg::SPLIT_W)
             + ray_tri_pkg::wide_t'(plo_max_r);
    win_fail = (tn16 < win_min) || (tn16 > win_max);
  end

  // restoring divider, one quotient bit per stage
  always_comb begin
    for (int j = 1; j <= ray_tri_pkg::QUO_W; j++) begin
      ds[j] = ray_tri_pkg::rem_t'(ddet_r[j-1]) << (ray_tri_pkg::QUO_W - j);
      ge[j] = drem_r[j-1] >= ds[j];
    end
  end

  // stages 41..43: signed distance, hit point
  always_comb begin
    tq_nxt = dneg_r[ray_tri_pkg::QUO_W]
           ? -ray_tri_pkg::tq_t'({1'b0, dq_r[ray_tri_pkg::QUO_W]})
           :  ray_tri_pkg::tq_t'({1'b0, dq_r[ray_tri_pkg::QUO_W]});
    lim_hi = ray_tri_pkg::pt_t'({1'b0, {(ray_tri_pkg::COMP_W-1){1'b1}}});
    lim_lo = ray_tri_pkg::pt_t'(ray_tri_pkg::comp_t'({1'b1, {(ray_tri_pkg::COMP_W-1){1'b0}}}));
    point_nxt = '0;
    for (int k = 0; k < ray_tri_pkg::VEC_N; k++) begin
      pt[k] = ray_tri_pkg::pt_t'(pr42_r[k] >>> ray_tri_pkg::DIST_FRAC)
            + ray_tri_pkg::pt_t'(o_r[ray_tri_pkg::PIPE_LAT-1][k]);
      if (pt[k] > lim_hi) begin
        pt[k] = lim_hi;
      end else if (pt[k] < lim_lo) begin
        pt[k] = lim_lo;
      end
      point_nxt[k*ray_tri_pkg::COMP_W +: ray_tri_pkg::COMP_W] = pt[k][ray_tri_pkg::COMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < ray_tri_pkg::VEC_N; k++) begin
      o_r[1][k]  <= in_o[k];
      d_r[1][k]  <= in_d[k];
      tv_r[1][k] <= tv_nxt[k];
    end
    for (int s = 2; s < ray_tri_pkg::PIPE_LAT; s++) begin
      o_r[s] <= o_r[s-1];
      d_r[s] <= d_r[s-1];
    end
    tv_r[2] <= tv_r[1];
    tv_r[3] <= tv_r[2];
    tmin_r[1] <= in_item.min_distance;
    tmax_r[1] <= in_item.max_distance;
    for (int s = 2; s <= ray_tri_pkg::DIV_FIRST - 2; s++) begin
      tmin_r[s] <= tmin_r[s-1];
      tmax_r[s] <= tmax_r[s-1];
    end

    pm_r     <= pm_nxt;
    qm_r     <= qm_nxt;
    pv_r     <= pv_nxt;
    qv_r     <= qv_nxt;
    dp_det_r <= dp_det_nxt;
    dp_un_r  <= dp_un_nxt;
    dp_vn_r  <= dp_vn_nxt;
    dp_tn_r  <= dp_tn_nxt;
    det5_r   <= dp_det_r[0] + dp_det_r[1] + dp_det_r[2];
    un5_r    <= dp_un_r[0] + dp_un_r[1] + dp_un_r[2];
    vn5_r    <= dp_vn_r[0] + dp_vn_r[1] + dp_vn_r[2];
    tn5_r    <= dp_tn_r[0] + dp_tn_r[1] + dp_tn_r[2];

    rej6_r  <= thr_fail || (det5_r == '0);
    dmag6_r <= ray_tri_pkg::dmag_t'(det_abs);
    un6_r   <= det_neg ? -un5_r : un5_r;
    vn6_r   <= det_neg ? -vn5_r : vn5_r;
    tn6_r   <= det_neg ? -tn5_r : tn5_r;

    rej7_r    <= rej6_r || bary_fail;
    dmag7_r   <= dmag6_r;
    tn7_r     <= tn6_r;
    plo_min_r <= ray_tri_pkg::part_t'(tmin_r[ray_tri_pkg::DIV_FIRST-2])
               * ray_tri_pkg::part_t'({1'b0, dmag6_r[ray_tri_pkg::SPLIT_W-1:0]});
    phi_min_r <= ray_tri_pkg::part_t'(tmin_r[ray_tri_pkg::DIV_FIRST-2])
               * ray_tri_pkg::part_t'({1'b0, dmag6_r[ray_tri_pkg::DMAG_W-1:ray_tri_pkg::SPLIT_W]});
    plo_max_r <= ray_tri_pkg::part_t'(tmax_r[ray_tri_pkg::DIV_FIRST-2])
               * ray_tri_pkg::part_t'({1'b0, dmag6_r[ray_tri_pkg::SPLIT_W-1:0]});
    phi_max_r <= ray_tri_pkg::part_t'(tmax_r[ray_tri_pkg::DIV_FIRST-2])
               * ray_tri_pkg::part_t'({1'b0, dmag6_r[ray_tri_pkg::DMAG_W-1:ray_tri_pkg::SPLIT_W]});

    dhit_r[0] <= !rej7_r && !win_fail;
    dneg_r[0] <= tn16[ray_tri_pkg::REM_W];
    drem_r[0] <= ray_tri_pkg::rem_t'(tn16[ray_tri_pkg::REM_W] ? -tn16 : tn16);
    dq_r[0]   <= '0;
    ddet_r[0] <= dmag7_r;
    for (int j = 1; j <= ray_tri_pkg::QUO_W; j++) begin
      dhit_r[j] <= dhit_r[j-1];
      dneg_r[j] <= dneg_r[j-1];
      ddet_r[j] <= ddet_r[j-1];
      drem_r[j] <= ge[j] ? drem_r[j-1] - ds[j] : drem_r[j-1];
      dq_r[j]   <= ge[j] ? (dq_r[j-1] | (ray_tri_pkg::quo_t'(1) << (ray_tri_pkg::QUO_W - j)))
                         : dq_r[j-1];
    end

    tq41_r  <= tq_nxt;
    hit41_r <= dhit_r[ray_tri_pkg::QUO_W];
    tq42_r  <= tq41_r;
    hit42_r <= hit41_r;
    for (int k = 0; k < ray_tri_pkg::VEC_N; k++) begin
      pr42_r[k] <= ray_tri_pkg::prod_t'(tq41_r)
                 * ray_tri_pkg::prod_t'(d_r[ray_tri_pkg::PIPE_LAT-2][k]);
    end

    out_item_r.hit          <= hit42_r;
    out_item_r.hit_distance <= hit42_r ? ray_tri_pkg::dist_t'(tq42_r) : '0;
    out_item_r.hit_point    <= hit42_r ? point_nxt : '0;
    out_item_r.hit_normal   <= hit42_r ? face_normal_r : '0;
  end

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(ray_tri_pkg::PIPE_LAT) out_valid)
    else $error("transfer in without result strobe at fixed latency");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, ray_tri_pkg::PIPE_LAT))
    else $error("result strobe without matching input transfer");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.hit) |->
      (out_item.hit_distance == '0 && out_item.hit_point == '0
       && out_item.hit_normal == '0))
    else $error("miss result carries nonzero payload");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[ray_tri_pkg::DIV_FIRST+ray_tri_pkg::QUO_W] && dhit_r[ray_tri_pkg::QUO_W]) |->
      (drem_r[ray_tri_pkg::QUO_W] < ray_tri_pkg::rem_t'(ddet_r[ray_tri_pkg::QUO_W])))
    else $error("divider remainder not below determinant on hit");
`endif

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ray_triangle_intersect. A short table of directed
// rays (hits, misses, window and threshold edges, field extremes) is followed
// by randomized phases, each with its own triangle, epsilon and cull setting.
// Most random rays aim at a point in or near the triangle; the rest are noise.
// Results are compared against table entries or an exact wide-integer tracer.
// ----------------------------------------------------------------------------
module testbench;

  typedef logic signed [127:0] acc_t;

  typedef struct {
    ray_tri_pkg::in_item_t  item;
    bit                     typed;
    ray_tri_pkg::out_item_t want;
  } ray_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  ray_tri_pkg::in_item_t  in_item;
  logic                   out_valid;
  ray_tri_pkg::out_item_t out_item;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [ray_tri_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ray_tri_pkg::CFG_DATA_W-1:0] cfg_data;

  ray_tri_pkg::vec_t tri_vertex, tri_ab, tri_ac, tri_normal;
  ray_tri_pkg::eps_t tri_eps;
  bit                tri_cull;

  ray_tri_pkg::out_item_t hit_queue[$];
  int                     errors;
  bit                     no_gaps;

  ray_triangle_intersect dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic ray_tri_pkg::vec_t vec3(longint x, longint y, longint z);
    ray_tri_pkg::vec_t v;
    v[0 +: ray_tri_pkg::COMP_W]                      = x[ray_tri_pkg::COMP_W-1:0];
    v[ray_tri_pkg::COMP_W +: ray_tri_pkg::COMP_W]    = y[ray_tri_pkg::COMP_W-1:0];
    v[2*ray_tri_pkg::COMP_W +: ray_tri_pkg::COMP_W]  = z[ray_tri_pkg::COMP_W-1:0];
    return v;
  endfunction

  function automatic longint comp_of(ray_tri_pkg::vec_t v, int k);
    ray_tri_pkg::comp_t c;
    c = v[k*ray_tri_pkg::COMP_W +: ray_tri_pkg::COMP_W];
    return longint'(c);
  endfunction

  function automatic ray_tri_pkg::out_item_t trace_ray(ray_tri_pkg::in_item_t r);
    longint o[3], d[3], a[3], ab[3], ac[3], tv[3], pv[3], qv[3];
    acc_t det, un, vn, tn, tn16, tq, eps_w;
    longint p;
    ray_tri_pkg::vec_t pt;
    ray_tri_pkg::out_item_t res;
    res = '0;
    pt = '0;
    for (int k = 0; k < 3; k++) begin
      o[k]  = comp_of(r.ray_origin, k);
      d[k]  = comp_of(r.ray_direction, k);
      a[k]  = comp_of(tri_vertex, k);
      ab[k] = comp_of(tri_ab, k);
      ac[k] = comp_of(tri_ac, k);
      tv[k] = o[k] - a[k];
    end
    pv[0] = d[1]*ac[2] - d[2]*ac[1];
    pv[1] = d[2]*ac[0] - d[0]*ac[2];
    pv[2] = d[0]*ac[1] - d[1]*ac[0];
    qv[0] = tv[1]*ab[2] - tv[2]*ab[1];
    qv[1] = tv[2]*ab[0] - tv[0]*ab[2];
    qv[2] = tv[0]*ab[1] - tv[1]*ab[0];
    det = acc_t'(ab[0])*acc_t'(pv[0]) + acc_t'(ab[1])*acc_t'(pv[1])
        + acc_t'(ab[2])*acc_t'(pv[2]);
    un  = acc_t'(tv[0])*acc_t'(pv[0]) + acc_t'(tv[1])*acc_t'(pv[1])
        + acc_t'(tv[2])*acc_t'(pv[2]);
    vn  = acc_t'(d[0])*acc_t'(qv[0]) + acc_t'(d[1])*acc_t'(qv[1])
        + acc_t'(d[2])*acc_t'(qv[2]);
    tn  = acc_t'(ac[0])*acc_t'(qv[0]) + acc_t'(ac[1])*acc_t'(qv[1])
        + acc_t'(ac[2])*acc_t'(qv[2]);
    eps_w = acc_t'(tri_eps) <<< (3*ray_tri_pkg::FRAC_W);
    if (tri_cull) begin
      if ((det <<< ray_tri_pkg::DIST_FRAC) < eps_w) return res;
    end else begin
      if (((det < 0 ? -det : det) <<< ray_tri_pkg::DIST_FRAC) < eps_w) return res;
    end
    if (det == 0) return res;
    if (det < 0) begin
      det = -det; un = -un; vn = -vn; tn = -tn;
    end
    if (un < 0 || un > det) return res;
    if (vn < 0 || un + vn > det) return res;
    tn16 = tn <<< ray_tri_pkg::DIST_FRAC;
    if (tn16 < acc_t'(r.min_distance) * det) return res;
    if (tn16 > acc_t'(r.max_distance) * det) return res;
    tq = tn16 / det;
    for (int k = 0; k < 3; k++) begin
      p = o[k] + ((longint'(tq) * d[k]) >>> ray_tri_pkg::DIST_FRAC);
      if (p > (64'sd1 <<< (ray_tri_pkg::COMP_W-1)) - 1)
        p = (64'sd1 <<< (ray_tri_pkg::COMP_W-1)) - 1;
      if (p < -(64'sd1 <<< (ray_tri_pkg::COMP_W-1)))
        p = -(64'sd1 <<< (ray_tri_pkg::COMP_W-1));
      pt[k*ray_tri_pkg::COMP_W +: ray_tri_pkg::COMP_W] = p[ray_tri_pkg::COMP_W-1:0];
    end
    res.hit          = 1'b1;
    res.hit_distance = tq[ray_tri_pkg::DIST_W-1:0];
    res.hit_point    = pt;
    res.hit_normal   = tri_normal;
    return res;
  endfunction

  task automatic write_reg(ray_tri_pkg::cfg_reg_t idx,
                           logic [ray_tri_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      ray_tri_pkg::CFG_VERTEX_A:    tri_vertex = val[ray_tri_pkg::VEC_W-1:0];
      ray_tri_pkg::CFG_EDGE_AB:     tri_ab     = val[ray_tri_pkg::VEC_W-1:0];
      ray_tri_pkg::CFG_EDGE_AC:     tri_ac     = val[ray_tri_pkg::VEC_W-1:0];
      ray_tri_pkg::CFG_FACE_NORMAL: tri_normal = val[ray_tri_pkg::VEC_W-1:0];
      ray_tri_pkg::CFG_EPSILON:     tri_eps    = val[ray_tri_pkg::EPS_W-1:0];
      ray_tri_pkg::CFG_CULL_MODE:   tri_cull   = val[0];
      default: ;
    endcase
  endtask

  task automatic send_ray(ray_tri_pkg::in_item_t it, bit typed,
                          ray_tri_pkg::out_item_t want);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    hit_queue.push_back(typed ? want : trace_ray(it));
  endtask

  task automatic drain;
    start <= 1'b0;
    wait (hit_queue.size() == 0);
    repeat (ray_tri_pkg::PIPE_LAT + 8) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic longint rand_signed(int span);
    return longint'($urandom_range(0, 2*span)) - span;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (hit_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", out_item);
      end else begin
        ray_tri_pkg::out_item_t want;
        want = hit_queue.pop_front();
        if (out_item.hit !== want.hit || out_item.hit_distance !== want.hit_distance ||
            out_item.hit_point !== want.hit_point ||
            out_item.hit_normal !== want.hit_normal) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp hit=%b t=%h pt=%h n=%h / got hit=%b t=%h pt=%h n=%h",
                     want.hit, want.hit_distance, want.hit_point, want.hit_normal,
                     out_item.hit, out_item.hit_distance, out_item.hit_point,
                     out_item.hit_normal);
        end
      end
    end
  end

  initial begin
    ray_row_t               rows[$];
    ray_tri_pkg::in_item_t  it;
    ray_tri_pkg::out_item_t nohit;
    ray_tri_pkg::vec_t      up;
    longint                 pnt[3], dir[3], org[3], u, v, t12;
    int                     items;

    errors = 0;
    no_gaps = 1'b0;
    tri_vertex = '0; tri_ab = '0; tri_ac = '0; tri_normal = '0;
    tri_eps = ray_tri_pkg::eps_t'(16); tri_cull = 1'b0;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unit right triangle in the z = 0 plane, facing +z
    up = vec3(0, 0, 4096);
    write_reg(ray_tri_pkg::CFG_VERTEX_A, '0);
    write_reg(ray_tri_pkg::CFG_EDGE_AB, {1'b0, vec3(4096, 0, 0)});
    write_reg(ray_tri_pkg::CFG_EDGE_AC, {1'b0, vec3(0, 4096, 0)});
    write_reg(ray_tri_pkg::CFG_FACE_NORMAL, {1'b0, up});
    nohit = '0;

    rows.push_back('{'{vec3(1024, 1024, 4096), vec3(0, 0, -4096), 32'sh8000_0000,
                      32'sh7fff_ffff}, 1'b1,
                     '{1'b1, 32'sh0001_0000, vec3(1024, 1024, 0), up}});
    rows.push_back('{'{vec3(8192, 1024, 4096), vec3(0, 0, -4096), 32'sh8000_0000,
                      32'sh7fff_ffff}, 1'b1, nohit});
    rows.push_back('{'{vec3(1024, 1024, 4096), vec3(4096, 0, 0), 32'sh8000_0000,
                      32'sh7fff_ffff}, 1'b1, nohit});
    rows.push_back('{'{vec3(1024, 1024, 4096), vec3(0, 0, -4096), 32'sh0002_0000,
                      32'sh0000_0000}, 1'b1, nohit});
    rows.push_back('{'{vec3(1024, 1024, 4096), vec3(0, 0, -4096), 32'sh0000_0000,
                      32'sh0000_8000}, 1'b1, nohit});
    rows.push_back('{'{vec3(1024, 1024, 4096), vec3(0, 0, -4096), 32'sh0001_0000,
                      32'sh0001_0000}, 1'b0, nohit});
    rows.push_back('{'{vec3(0, 2048, 4096), vec3(0, 0, -4096), 32'sh8000_0000,
                      32'sh7fff_ffff}, 1'b0, nohit});
    rows.push_back('{'{vec3(2048, 2048, 4096), vec3(0, 0, -4096), 32'sh8000_0000,
                      32'sh7fff_ffff}, 1'b0, nohit});
    rows.push_back('{'{vec3(-1, 1024, 4096), vec3(0, 0, -4096), 32'sh8000_0000,
                      32'sh7fff_ffff}, 1'b0, nohit});
    rows.push_back('{'{vec3(1024, 1024, -4096), vec3(0, 0, 4096), 32'sh8000_0000,
                      32'sh7fff_ffff}, 1'b0, nohit});
    rows.push_back('{'{vec3(1024, 1024, 4096), vec3(0, 0, -1), 32'sh8000_0000,
                      32'sh7fff_ffff}, 1'b0, nohit});
    rows.push_back('{'{vec3(1024, 1024, 4096), vec3(0, 0, 4096), 32'sh8000_0000,
                      32'sh7fff_ffff}, 1'b0, nohit});
    rows.push_back('{'{{ray_tri_pkg::VEC_W{1'b1}}, {ray_tri_pkg::VEC_W{1'b1}},
                      32'sh7fff_ffff, 32'sh8000_0000}, 1'b0, nohit});
    rows.push_back('{'{vec3(1048575, 1048575, 1048575), vec3(-1048576, -1048576, -1048576),
                      32'sh8000_0000, 32'sh7fff_ffff}, 1'b0, nohit});
    rows.push_back('{'{vec3(-1048576, -1048576, 1048575), vec3(1048575, 1048575, -1048576),
                      32'sh8000_0000, 32'sh7fff_ffff}, 1'b0, nohit});
    rows.push_back('{'{'0, '0, '0, '0}, 1'b1, nohit});
    foreach (rows[i]) send_ray(rows[i].item, rows[i].typed, rows[i].want);
    drain();

    // same triangle, culling on, zero threshold: back faces and grazing rays
    write_reg(ray_tri_pkg::CFG_CULL_MODE, 64'd1);
    write_reg(ray_tri_pkg::CFG_EPSILON, 64'd0);
    foreach (rows[i]) send_ray(rows[i].item, 1'b0, nohit);
    drain();
    items = 2 * rows.size();

    for (int ph = 0; items < 950; ph++) begin
      write_reg(ray_tri_pkg::CFG_VERTEX_A, (ph % 4 == 3) ? rand64() :
                {$urandom_range(0, 1) ? 1'b1 : 1'b0,
                 vec3(rand_signed(16384), rand_signed(16384), rand_signed(16384))});
      write_reg(ray_tri_pkg::CFG_EDGE_AB, (ph % 4 == 3) ? rand64() :
                {1'b0, vec3(rand_signed(8192), rand_signed(8192), rand_signed(8192))});
      write_reg(ray_tri_pkg::CFG_EDGE_AC, (ph % 4 == 3) ? rand64() :
                {1'b0, vec3(rand_signed(8192), rand_signed(8192), rand_signed(8192))});
      write_reg(ray_tri_pkg::CFG_FACE_NORMAL, rand64());
      write_reg(ray_tri_pkg::CFG_EPSILON,
                ph == 0 ? 64'd0 : ph == 1 ? 64'd65535 : 64'($urandom_range(0, 255)));
      write_reg(ray_tri_pkg::CFG_CULL_MODE,
                {$urandom_range(0, 1) ? 32'hffff_ffff : 32'h0, 31'h0, 1'(ph % 2)});
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 110; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          it.ray_origin    = rand64();
          it.ray_direction = rand64();
          it.min_distance  = $urandom;
          it.max_distance  = $urandom;
        end else begin
          u = longint'($urandom_range(0, 4096));
          v = longint'($urandom_range(0,
                32'(4096 - u + ($urandom_range(0, 7) == 0 ? 200 : 0))));
          t12 = longint'($urandom_range(0, 16384));
          for (int k = 0; k < 3; k++) begin
            dir[k] = rand_signed(8192);
            pnt[k] = comp_of(tri_vertex, k) +
                     ((u * comp_of(tri_ab, k) + v * comp_of(tri_ac, k))
                      >>> ray_tri_pkg::FRAC_W);
            org[k] = pnt[k] - ((t12 * dir[k]) >>> ray_tri_pkg::FRAC_W);
          end
          it.ray_origin    = vec3(org[0], org[1], org[2]);
          it.ray_direction = vec3(dir[0], dir[1], dir[2]);
          it.min_distance  = $urandom_range(0, 3) == 0 ?
                             ray_tri_pkg::dist_t'($urandom_range(0, 262144)) :
                             -ray_tri_pkg::dist_t'($urandom_range(0, 65536));
          it.max_distance  = $urandom_range(0, 3) == 0 ?
                             ray_tri_pkg::dist_t'($urandom_range(0, 262144)) :
                             ray_tri_pkg::dist_t'(32'h7fff_ffff - $urandom_range(0, 65536));
        end
        send_ray(it, 1'b0, nohit);
        items++;
      end
      drain();
    end

    if (errors == 0 && hit_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: ray_triangle_intersect.f
src/ray_tri_pkg.sv
src/ray_triangle_intersect.sv
sim/testbench.sv
